>>> src/lidar_frustum_point_filter_defines.svh
// Assertion macros used by the checker file of the frustum point filter.
`ifndef LIDAR_FRUSTUM_POINT_FILTER_DEFINES_SVH
`define LIDAR_FRUSTUM_POINT_FILTER_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define LFPF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define LFPF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/lfpf_pkg.sv
`timescale 1ns / 1ps

package lfpf_pkg;

  // Coordinate width and fraction bits of the rotation coefficients.
  localparam int COORD_BITS     = 24;
  localparam int COEF_FRAC_BITS = 14;

  // Fixed register geometry.
  localparam int COEF_W    = 16;
  localparam int ROW_W     = 48;
  localparam int SHIFT_W   = 24;
  localparam int TANH_W    = 24;
  localparam int TANV_W    = 32;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  // Derived datapath widths.
  localparam int PROD_W = COEF_W + COORD_BITS;
  localparam int ACC_W  = PROD_W + 2;
  localparam int ROT_W  = ACC_W - COEF_FRAC_BITS;
  localparam int S_W    = ((ROT_W > SHIFT_W) ? ROT_W : SHIFT_W) + 1;
  localparam int MAG_W  = S_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int RXY_W  = SQ_W + 1;
  localparam int R3_W   = SQ_W + 2;
  localparam int LO_W   = (RXY_W + 1) / 2;
  localparam int HI_W   = RXY_W - LO_W;
  localparam int VR_W   = RXY_W + TANV_W;
  localparam int HZ_W   = MAG_W + TANH_W;

  // Stream payload widths, padded to whole bytes.
  localparam int TDATA_W = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int TUSER_W = 8;

  // Register reset values.
  localparam logic [COEF_W-1:0] COEF_ONE       = COEF_W'(1) << COEF_FRAC_BITS;
  localparam logic [ROW_W-1:0]  ROT_X_RESET    = ROW_W'(COEF_ONE) << 32;
  localparam logic [ROW_W-1:0]  ROT_Y_RESET    = ROW_W'(COEF_ONE) << 16;
  localparam logic [ROW_W-1:0]  ROT_Z_RESET    = ROW_W'(COEF_ONE);
  localparam logic [ROW_W-1:0]  RANGE_SQ_RESET = 48'd10000000000;
  localparam logic [TANH_W-1:0] TANH_RESET     = 24'd65536;
  localparam logic [TANV_W-1:0] TANV_RESET     = 32'd65536;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_ROW_X,
    REG_ROT_ROW_Y,
    REG_ROT_ROW_Z,
    REG_SHIFT_XY,
    REG_SHIFT_Z,
    REG_RANGE_LIMIT_SQ,
    REG_TAN_HALF_HORIZ,
    REG_TAN_HALF_VERT_SQ
  } reg_index_t;

  // Reject causes, in the order the checks are tested.
  typedef enum logic [2:0] {
    CAUSE_KEPT,
    CAUSE_FAR,
    CAUSE_BEHIND,
    CAUSE_HORIZ,
    CAUSE_VERT
  } cause_t;

  // One point as it travels down the pipeline.
  typedef struct packed {
    logic                         last;
    logic signed [COORD_BITS-1:0] z;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } point_t;

  // Transform settings seen by the rotation stages.
  typedef struct packed {
    logic [ROW_W-1:0]   row_x;
    logic [ROW_W-1:0]   row_y;
    logic [ROW_W-1:0]   row_z;
    logic [ROW_W-1:0]   shift_xy;
    logic [SHIFT_W-1:0] shift_z;
  } xform_cfg_t;

  // Load enables of the two rotation stages.
  typedef struct packed {
    logic s1;
    logic s2;
  } rot_en_t;

endpackage

>>> src/lfpf_rotate.sv
`timescale 1ns / 1ps

module lfpf_rotate
  import lfpf_pkg::*;
(
  input  logic                  clk,
  input  rot_en_t               en,
  input  point_t                pos,
  input  xform_cfg_t            cfg,
  output logic signed [S_W-1:0] sx,
  output logic signed [S_W-1:0] sy,
  output logic signed [S_W-1:0] sz
);

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  logic [ROW_W-1:0]               rows  [3];
  logic signed [COORD_BITS-1:0]   coord [3];
  logic signed [PROD_W-1:0]       prod_next [3][3];
  logic signed [PROD_W-1:0]       prod      [3][3];
  logic signed [S_W-1:0]          s_next    [3];
  logic signed [SHIFT_W-1:0]      shift     [3];

  assign rows[0]  = cfg.row_x;
  assign rows[1]  = cfg.row_y;
  assign rows[2]  = cfg.row_z;
  assign coord[0] = pos.x;
  assign coord[1] = pos.y;
  assign coord[2] = pos.z;
  assign shift[0] = cfg.shift_xy[ROW_W-1:SHIFT_W];
  assign shift[1] = cfg.shift_xy[SHIFT_W-1:0];
  assign shift[2] = cfg.shift_z;

  // Stage 1: nine coefficient products; the top coefficient of a row multiplies world x.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_next[r][k] = $signed(rows[r][(2 - k) * COEF_W +: COEF_W]) * coord[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod <= prod_next;
    end
  end

  // Stage 2: row sums, round half up to whole millimetres, add the translation.
  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] rnd;
    logic signed [ROT_W-1:0] rot;
    for (int r = 0; r < 3; r++) begin
      acc = ACC_W'(prod[r][0]) + ACC_W'(prod[r][1]) + ACC_W'(prod[r][2]);
      rnd = acc + RND_HALF;
      rot = ROT_W'(rnd >>> COEF_FRAC_BITS);
      s_next[r] = S_W'(rot) + S_W'(shift[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      sx <= s_next[0];
      sy <= s_next[1];
      sz <= s_next[2];
    end
  end

endmodule

>>> src/lidar_frustum_point_filter.sv
`timescale 1ns / 1ps

// Channel  | Ports                         | Contents
// ---------+-------------------------------+---------------------------------------
// input    | s_tvalid s_tready s_tdata     | pos_x, pos_y, pos_z; s_tlast = end_of_cloud
// output   | m_tvalid m_tready m_tdata     | out_x, out_y, out_z; m_tuser = keep,
//          | m_tuser m_tlast               | reject_cause; m_tlast = cloud_done
// config   | cfg_we cfg_index cfg_data     | one register written per cycle
//
// One point per cycle sustained while the output is not stalled; a point enters stage 1
// at its input transaction and passes through the six-stage pipeline (products, rotation,
// squares, range sums, split vertical product, final compare) to the output register.
// Synchronous reset clears the stage valid bits and loads the register defaults.
// Each stage holds while its successor is full and stalled; a stalled output lets
// earlier stages take new points only until their bubbles are filled.

module lidar_frustum_point_filter
  import lfpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // pos_x [23:0], pos_y [47:24], pos_z [71:48]
  input  logic [TDATA_W-1:0]   s_tdata,
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // out_x [23:0], out_y [47:24], out_z [71:48]
  output logic [TDATA_W-1:0]   m_tdata,
  // keep [0], reject_cause [3:1], zero [7:4]
  output logic [TUSER_W-1:0]   m_tuser,
  output logic                 m_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int NSTAGE = 6;

  xform_cfg_t        xcfg;
  logic [ROW_W-1:0]  range_sq;
  logic [TANH_W-1:0] tan_h;
  logic [TANV_W-1:0] tan_v_sq;

  logic [NSTAGE:1]   vld;
  logic [NSTAGE+1:1] rdy;
  point_t            pt [1:NSTAGE];
  point_t            pos_in;
  rot_en_t           rot_en;

  logic signed [S_W-1:0] sx, sy, sz;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      xcfg.row_x    <= ROT_X_RESET;
      xcfg.row_y    <= ROT_Y_RESET;
      xcfg.row_z    <= ROT_Z_RESET;
      xcfg.shift_xy <= '0;
      xcfg.shift_z  <= '0;
      range_sq      <= RANGE_SQ_RESET;
      tan_h         <= TANH_RESET;
      tan_v_sq      <= TANV_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_ROT_ROW_X:        xcfg.row_x    <= cfg_data;
        REG_ROT_ROW_Y:        xcfg.row_y    <= cfg_data;
        REG_ROT_ROW_Z:        xcfg.row_z    <= cfg_data;
        REG_SHIFT_XY:         xcfg.shift_xy <= cfg_data;
        REG_SHIFT_Z:          xcfg.shift_z  <= cfg_data[SHIFT_W-1:0];
        REG_RANGE_LIMIT_SQ:   range_sq      <= cfg_data;
        REG_TAN_HALF_HORIZ:   tan_h         <= cfg_data[TANH_W-1:0];
        REG_TAN_HALF_VERT_SQ: tan_v_sq      <= cfg_data[TANV_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage can load when it is empty or its content moves on in this cycle.
  always_comb begin
    rdy[NSTAGE+1] = m_tready;
    for (int i = NSTAGE; i >= 1; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign s_tready = rdy[1];
  assign m_tvalid = vld[NSTAGE];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int i = 2; i <= NSTAGE; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // The world point and the end mark ride along unchanged.
  assign pos_in.x    = s_tdata[COORD_BITS-1:0];
  assign pos_in.y    = s_tdata[2*COORD_BITS-1:COORD_BITS];
  assign pos_in.z    = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign pos_in.last = s_tlast;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      pt[1] <= pos_in;
    end
    for (int i = 2; i <= NSTAGE; i++) begin
      if (rdy[i]) begin
        pt[i] <= pt[i-1];
      end
    end
  end

  // Stages 1 and 2: rotation and translation into the sensor frame.
  assign rot_en.s1 = rdy[1];
  assign rot_en.s2 = rdy[2];

  lfpf_rotate u_rotate (
    .clk (clk),
    .en  (rot_en),
    .pos (pos_in),
    .cfg (xcfg),
    .sx  (sx),
    .sy  (sy),
    .sz  (sz)
  );

  // Stage 3: magnitudes, squares and the horizontal bound.
  logic [MAG_W-1:0] ax, ay_mag, az;
  logic [SQ_W-1:0]  ax2, ay2, az2_3;
  logic [HZ_W-1:0]  th_ax;
  logic [MAG_W-1:0] ay3;
  logic             behind3;

  assign ax     = MAG_W'(sx[S_W-1] ? -sx : sx);
  assign ay_mag = MAG_W'(sy[S_W-1] ? -sy : sy);
  assign az     = MAG_W'(sz[S_W-1] ? -sz : sz);

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      ax2     <= ax * ax;
      ay2     <= ay_mag * ay_mag;
      az2_3   <= az * az;
      th_ax   <= tan_h * ax;
      ay3     <= ay_mag;
      behind3 <= sx[S_W-1] || (sx == '0);
    end
  end

  // Stage 4: squared range and the far and horizontal checks.
  logic [RXY_W-1:0] rxy_next, rxy4;
  logic [R3_W-1:0]  r3;
  logic [SQ_W-1:0]  az2_4;
  logic             far4, behind4, horiz4;

  assign rxy_next = RXY_W'(ax2) + RXY_W'(ay2);
  assign r3       = R3_W'(rxy_next) + R3_W'(az2_3);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      rxy4    <= rxy_next;
      az2_4   <= az2_3;
      far4    <= r3 > R3_W'(range_sq);
      behind4 <= behind3;
      horiz4  <= HZ_W'({ay3, 16'b0}) > th_ax;
    end
  end

  // Stage 5: vertical bound split into two partial products.
  logic [TANV_W+LO_W-1:0] pl5;
  logic [TANV_W+HI_W-1:0] ph5;
  logic [SQ_W-1:0]        az2_5;
  logic                   far5, behind5, horiz5;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      pl5     <= tan_v_sq * rxy4[LO_W-1:0];
      ph5     <= tan_v_sq * rxy4[RXY_W-1:LO_W];
      az2_5   <= az2_4;
      far5    <= far4;
      behind5 <= behind4;
      horiz5  <= horiz4;
    end
  end

  // Stage 6: vertical check and the reject cause in test order.
  logic [VR_W-1:0] vert_rhs;
  logic            vert;
  cause_t          cause_next, cause6;
  logic            keep6;

  assign vert_rhs = (VR_W'(ph5) << LO_W) + VR_W'(pl5);
  assign vert     = VR_W'({az2_5, 16'b0}) > vert_rhs;

  always_comb begin
    if (far5) begin
      cause_next = CAUSE_FAR;
    end else if (behind5) begin
      cause_next = CAUSE_BEHIND;
    end else if (horiz5) begin
      cause_next = CAUSE_HORIZ;
    end else if (vert) begin
      cause_next = CAUSE_VERT;
    end else begin
      cause_next = CAUSE_KEPT;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      cause6 <= cause_next;
      keep6  <= (cause_next == CAUSE_KEPT);
    end
  end

  // Output transaction.
  assign m_tdata = TDATA_W'({pt[NSTAGE].z, pt[NSTAGE].y, pt[NSTAGE].x});
  assign m_tuser = TUSER_W'({cause6, keep6});
  assign m_tlast = pt[NSTAGE].last;

endmodule

>>> src/lfpf_checker.sv
`timescale 1ns / 1ps
`include "lidar_frustum_point_filter_defines.svh"

module lfpf_checker
  import lfpf_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic [TUSER_W-1:0] m_tuser
);

  // The keep flag agrees with a zero reject cause.
  `LFPF_ASSERT(a_keep_cause, clk, rst, m_tvalid |-> (m_tuser[0] == (m_tuser[3:1] == CAUSE_KEPT)), "keep flag disagrees with reject cause")

  // Only the five defined causes appear.
  `LFPF_ASSERT(a_cause_range, clk, rst, m_tvalid |-> (m_tuser[3:1] == CAUSE_KEPT || m_tuser[3:1] == CAUSE_FAR || m_tuser[3:1] == CAUSE_BEHIND || m_tuser[3:1] == CAUSE_HORIZ || m_tuser[3:1] == CAUSE_VERT), "undefined reject cause")

  // A stalled result holds its data.
  `LFPF_ASSERT(a_stall_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

  // With the output register empty the pipeline must take input.
  `LFPF_ASSERT(a_empty_ready, clk, rst, !m_tvalid |-> s_tready, "input blocked while output is empty")

  // Reset empties the pipeline.
  `LFPF_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "result present after reset")

endmodule

bind lidar_frustum_point_filter lfpf_checker u_lfpf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
